@@ sv/lvcs_pkg.sv @@
// ----------------------------------------------------------------------------
// lvcs_pkg: shared definitions for the line viewport clip sampler
// Widths, register indexes, reset values, result kinds and state types.
// ----------------------------------------------------------------------------
package lvcs_pkg;

    localparam int COORD_W = 32;          // Q16.16 coordinate
    localparam int DIFF_W  = 33;          // difference of two coordinates
    localparam int QUO_W   = 42;          // signed, saturated mul-div result
    localparam int CNT_W   = 7;           // point count and point index
    localparam int MAX_POINTS_DEF = 64;

    localparam logic signed [COORD_W-1:0] VIEW_LEFT_RST   = -32'sd655360;
    localparam logic signed [COORD_W-1:0] VIEW_RIGHT_RST  = 32'sd655360;
    localparam logic signed [COORD_W-1:0] VIEW_BOTTOM_RST = -32'sd655360;
    localparam logic signed [COORD_W-1:0] VIEW_TOP_RST    = 32'sd655360;

    typedef enum logic [1:0] {
        REG_LEFT   = 2'd0,
        REG_RIGHT  = 2'd1,
        REG_BOTTOM = 2'd2,
        REG_TOP    = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        KIND_LINE    = 2'd0,
        KIND_POINT   = 2'd1,
        KIND_NOTHING = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        MD_IDLE,
        MD_MUL,
        MD_DIV
    } md_state_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLIP,
        ST_CLIP_WAIT,
        ST_CLIP_END,
        ST_DRAW,
        ST_PT,
        ST_PT_WX,
        ST_PT_WY,
        ST_OUT
    } ctl_state_t;

endpackage

@@ sv/line_viewport_clip_sampler.sv @@
// ----------------------------------------------------------------------------
// line_viewport_clip_sampler: clip a line to a viewport and sample it
// Sequence: a segment with count zero passes through the draw state, and then
// its line result is registered. Each multiply-divide in the shared unit runs
// a load, 33 multiply steps, 66 divide steps and a registered result. Clipping
// an infinite line runs up to four of them; each sampled point other than the
// first takes two.
// Throughput: one item at a time; a new input is taken only after the last
// result of the previous item has been transferred.
// Reset: rst_n is asynchronous and active low; it returns the sequencer to
// idle, drops the output valid and loads the default viewport of +-10.0.
// ----------------------------------------------------------------------------
module line_viewport_clip_sampler
#(
    parameter int MAX_POINTS = lvcs_pkg::MAX_POINTS_DEF
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Configuration write port
    input  logic                                 cfg_we,
    input  logic [1:0]                           cfg_addr,
    input  logic [lvcs_pkg::COORD_W-1:0]         cfg_wdata,
    // Input channel
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [lvcs_pkg::COORD_W-1:0]  start_x,
    input  logic signed [lvcs_pkg::COORD_W-1:0]  start_y,
    input  logic signed [lvcs_pkg::COORD_W-1:0]  end_x,
    input  logic signed [lvcs_pkg::COORD_W-1:0]  end_y,
    input  logic                                 infinite_line,
    input  logic [lvcs_pkg::CNT_W-1:0]           point_count,
    // Output channel
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [1:0]                           result_kind,
    output logic signed [lvcs_pkg::COORD_W-1:0]  out_ax,
    output logic signed [lvcs_pkg::COORD_W-1:0]  out_ay,
    output logic signed [lvcs_pkg::COORD_W-1:0]  out_bx,
    output logic signed [lvcs_pkg::COORD_W-1:0]  out_by,
    output logic                                 last_of_run
);

    localparam int CW = lvcs_pkg::COORD_W;
    localparam int DW = lvcs_pkg::DIFF_W;
    localparam int QW = lvcs_pkg::QUO_W;
    localparam int NW = lvcs_pkg::CNT_W;
    localparam int SW = QW + 1;     // coordinate plus quotient, no overflow
    localparam logic [NW-1:0] MAX_N = NW'(MAX_POINTS);

    // Viewport registers
    logic signed [CW-1:0] left_reg, right_reg, bottom_reg, top_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg   <= lvcs_pkg::VIEW_LEFT_RST;
            right_reg  <= lvcs_pkg::VIEW_RIGHT_RST;
            bottom_reg <= lvcs_pkg::VIEW_BOTTOM_RST;
            top_reg    <= lvcs_pkg::VIEW_TOP_RST;
        end
        else if (cfg_we)
        begin
            unique case (lvcs_pkg::cfg_index_t'(cfg_addr))
                lvcs_pkg::REG_LEFT:   left_reg   <= cfg_wdata;
                lvcs_pkg::REG_RIGHT:  right_reg  <= cfg_wdata;
                lvcs_pkg::REG_BOTTOM: bottom_reg <= cfg_wdata;
                lvcs_pkg::REG_TOP:    top_reg    <= cfg_wdata;
                default:              ;
            endcase
        end
    end

    // Sequencer state
    lvcs_pkg::ctl_state_t state_reg, state_next;
    logic                 out_valid_reg, out_valid_next;

    // Working endpoints: the input endpoints, later the clipped ones.
    logic signed [CW-1:0] ax_reg, ax_next, ay_reg, ay_next;
    logic signed [CW-1:0] bx_reg, bx_next, by_reg, by_next;
    logic [NW-1:0]        n_reg, n_next;
    logic [NW-1:0]        i_reg, i_next;
    logic [1:0]           step_reg, step_next;
    logic [1:0]           nh_reg, nh_next;
    logic signed [CW-1:0] h0x_reg, h0x_next, h0y_reg, h0y_next;
    logic signed [CW-1:0] h1x_reg, h1x_next, h1y_reg, h1y_next;
    logic signed [CW-1:0] px_reg, px_next;

    // Output register
    logic [1:0]           kind_reg, kind_next;
    logic signed [CW-1:0] oax_reg, oax_next, oay_reg, oay_next;
    logic signed [CW-1:0] obx_reg, obx_next, oby_reg, oby_next;
    logic                 last_reg, last_next;

    // Shared multiply-divide unit
    logic                 md_start, md_done, md_busy;
    logic signed [DW-1:0] md_a, md_b, md_d;
    logic signed [QW-1:0] md_q;

    lvcs_muldiv u_muldiv
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (md_start),
        .a     (md_a),
        .b     (md_b),
        .d     (md_d),
        .done  (md_done),
        .busy  (md_busy),
        .q     (md_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lvcs_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ax_reg   <= ax_next;
        ay_reg   <= ay_next;
        bx_reg   <= bx_next;
        by_reg   <= by_next;
        n_reg    <= n_next;
        i_reg    <= i_next;
        step_reg <= step_next;
        nh_reg   <= nh_next;
        h0x_reg  <= h0x_next;
        h0y_reg  <= h0y_next;
        h1x_reg  <= h1x_next;
        h1y_reg  <= h1y_next;
        px_reg   <= px_next;
        kind_reg <= kind_next;
        oax_reg  <= oax_next;
        oay_reg  <= oay_next;
        obx_reg  <= obx_next;
        oby_reg  <= oby_next;
        last_reg <= last_next;
    end

    // Line direction and the border handled in the current clipping step.
    // Steps 0 and 1 are the left and right borders, 2 and 3 bottom and top.
    logic signed [DW-1:0] dx, dy, in_dx, in_dy;
    logic                 vert_step, need_div;
    logic signed [CW-1:0] border;
    logic signed [SW-1:0] other;
    logic                 cand_ok, dup, in_x_range, in_y_range;
    logic signed [CW-1:0] cand_x, cand_y;
    logic [NW-1:0]        n_sat;

    assign dx        = DW'(bx_reg) - DW'(ax_reg);
    assign dy        = DW'(by_reg) - DW'(ay_reg);
    assign in_dx     = DW'(end_x) - DW'(start_x);
    assign in_dy     = DW'(end_y) - DW'(start_y);
    assign vert_step = ~step_reg[1];
    assign need_div  = vert_step ? (dx != '0) : (dy != '0);
    assign n_sat     = (point_count > MAX_N) ? MAX_N : point_count;
    assign in_x_range = (ax_reg >= left_reg) && (ax_reg <= right_reg);
    assign in_y_range = (ay_reg >= bottom_reg) && (ay_reg <= top_reg);

    always_comb
    begin
        unique case (step_reg)
            2'd0:    border = left_reg;
            2'd1:    border = right_reg;
            2'd2:    border = bottom_reg;
            default: border = top_reg;
        endcase
    end

    // Candidate hit for the current step, either from the quotient or, for
    // a line parallel to the border pair, straight from the start point.
    always_comb
    begin
        other = '0;
        if (need_div)
        begin
            if (vert_step)
            begin
                other   = SW'(ay_reg) + SW'(md_q);
                cand_ok = (other >= SW'(bottom_reg)) && (other <= SW'(top_reg));
                cand_x  = border;
                cand_y  = other[CW-1:0];
            end
            else
            begin
                other   = SW'(ax_reg) + SW'(md_q);
                cand_ok = (other >= SW'(left_reg)) && (other <= SW'(right_reg));
                cand_x  = other[CW-1:0];
                cand_y  = border;
            end
        end
        else if (vert_step)
        begin
            cand_ok = in_x_range;
            cand_x  = ax_reg;
            cand_y  = step_reg[0] ? top_reg : bottom_reg;
        end
        else
        begin
            cand_ok = in_y_range;
            cand_x  = step_reg[0] ? right_reg : left_reg;
            cand_y  = ay_reg;
        end
    end

    // Corner hits arrive twice; a hit already kept is dropped.
    assign dup = ((nh_reg != 2'd0) && (h0x_reg == cand_x) && (h0y_reg == cand_y))
              || ((nh_reg == 2'd2) && (h1x_reg == cand_x) && (h1y_reg == cand_y));

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        ax_next   = ax_reg;
        ay_next   = ay_reg;
        bx_next   = bx_reg;
        by_next   = by_reg;
        n_next    = n_reg;
        i_next    = i_reg;
        step_next = step_reg;
        nh_next   = nh_reg;
        h0x_next  = h0x_reg;
        h0y_next  = h0y_reg;
        h1x_next  = h1x_reg;
        h1y_next  = h1y_reg;
        px_next   = px_reg;
        kind_next = kind_reg;
        oax_next  = oax_reg;
        oay_next  = oay_reg;
        obx_next  = obx_reg;
        oby_next  = oby_reg;
        last_next = last_reg;
        md_start  = 1'b0;
        md_a      = '0;
        md_b      = '0;
        md_d      = '0;
        in_ready  = (state_reg == lvcs_pkg::ST_IDLE);

        // Operands: clipping steps solve for the other coordinate at a border;
        // point steps scale the span by i / (n - 1).
        if (state_reg == lvcs_pkg::ST_CLIP)
        begin
            if (vert_step)
            begin
                md_a = dy;
                md_b = DW'(border) - DW'(ax_reg);
                md_d = dx;
            end
            else
            begin
                md_a = dx;
                md_b = DW'(border) - DW'(ay_reg);
                md_d = dy;
            end
        end
        else
        begin
            md_a = (state_reg == lvcs_pkg::ST_PT_WX) ? dy : dx;
            md_b = DW'(i_reg);
            md_d = DW'(n_reg - NW'(1));
        end

        unique case (state_reg)
            lvcs_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    ax_next   = start_x;
                    ay_next   = start_y;
                    bx_next   = end_x;
                    by_next   = end_y;
                    n_next    = n_sat;
                    i_next    = '0;
                    step_next = 2'd0;
                    nh_next   = 2'd0;
                    if (infinite_line && in_dx == '0 && in_dy == '0)
                    begin
                        kind_next      = lvcs_pkg::KIND_NOTHING;
                        oax_next       = '0;
                        oay_next       = '0;
                        obx_next       = '0;
                        oby_next       = '0;
                        last_next      = 1'b1;
                        out_valid_next = 1'b1;
                        state_next     = lvcs_pkg::ST_OUT;
                    end
                    else if (infinite_line)
                        state_next = lvcs_pkg::ST_CLIP;
                    else
                        state_next = lvcs_pkg::ST_DRAW;
                end
            end
            lvcs_pkg::ST_CLIP, lvcs_pkg::ST_CLIP_WAIT:
            begin
                if (state_reg == lvcs_pkg::ST_CLIP && need_div)
                begin
                    md_start   = 1'b1;
                    state_next = lvcs_pkg::ST_CLIP_WAIT;
                end
                else if (state_reg == lvcs_pkg::ST_CLIP || md_done)
                begin
                    if (cand_ok && !dup && nh_reg != 2'd2)
                    begin
                        if (nh_reg == 2'd0)
                        begin
                            h0x_next = cand_x;
                            h0y_next = cand_y;
                        end
                        else
                        begin
                            h1x_next = cand_x;
                            h1y_next = cand_y;
                        end
                        nh_next = nh_reg + 2'd1;
                    end
                    step_next  = step_reg + 2'd1;
                    state_next = (step_reg == 2'd3) ? lvcs_pkg::ST_CLIP_END
                                                    : lvcs_pkg::ST_CLIP;
                end
            end
            lvcs_pkg::ST_CLIP_END:
            begin
                if (nh_reg != 2'd2)
                begin
                    kind_next      = lvcs_pkg::KIND_NOTHING;
                    oax_next       = '0;
                    oay_next       = '0;
                    obx_next       = '0;
                    oby_next       = '0;
                    last_next      = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = lvcs_pkg::ST_OUT;
                end
                else
                begin
                    ax_next    = h0x_reg;
                    ay_next    = h0y_reg;
                    bx_next    = h1x_reg;
                    by_next    = h1y_reg;
                    state_next = lvcs_pkg::ST_DRAW;
                end
            end
            lvcs_pkg::ST_DRAW:
            begin
                if (n_reg == '0)
                begin
                    kind_next      = lvcs_pkg::KIND_LINE;
                    oax_next       = ax_reg;
                    oay_next       = ay_reg;
                    obx_next       = bx_reg;
                    oby_next       = by_reg;
                    last_next      = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = lvcs_pkg::ST_OUT;
                end
                else
                begin
                    state_next = lvcs_pkg::ST_PT;
                end
            end
            lvcs_pkg::ST_PT:
            begin
                // The first point is the start itself.
                if (i_reg == '0)
                begin
                    kind_next      = lvcs_pkg::KIND_POINT;
                    oax_next       = ax_reg;
                    oay_next       = ay_reg;
                    obx_next       = '0;
                    oby_next       = '0;
                    last_next      = (n_reg == NW'(1));
                    out_valid_next = 1'b1;
                    state_next     = lvcs_pkg::ST_OUT;
                end
                else
                begin
                    md_start   = 1'b1;
                    state_next = lvcs_pkg::ST_PT_WX;
                end
            end
            lvcs_pkg::ST_PT_WX:
            begin
                if (md_done)
                begin
                    px_next    = ax_reg + md_q[CW-1:0];
                    md_start   = 1'b1;
                    state_next = lvcs_pkg::ST_PT_WY;
                end
            end
            lvcs_pkg::ST_PT_WY:
            begin
                if (md_done)
                begin
                    kind_next      = lvcs_pkg::KIND_POINT;
                    oax_next       = px_reg;
                    oay_next       = ay_reg + md_q[CW-1:0];
                    obx_next       = '0;
                    oby_next       = '0;
                    last_next      = (i_reg == n_reg - NW'(1));
                    out_valid_next = 1'b1;
                    state_next     = lvcs_pkg::ST_OUT;
                end
            end
            lvcs_pkg::ST_OUT:
            begin
                if (out_ready)
                begin
                    out_valid_next = 1'b0;
                    if (last_reg)
                    begin
                        state_next = lvcs_pkg::ST_IDLE;
                    end
                    else
                    begin
                        i_next     = i_reg + NW'(1);
                        state_next = lvcs_pkg::ST_PT;
                    end
                end
            end
            default:
            begin
                state_next = lvcs_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid   = out_valid_reg;
    assign result_kind = kind_reg;
    assign out_ax      = oax_reg;
    assign out_ay      = oay_reg;
    assign out_bx      = obx_reg;
    assign out_by      = oby_reg;
    assign last_of_run = last_reg;

    // A result is only ever shown while the sequencer waits for its transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> state_reg == lvcs_pkg::ST_OUT)
        else $error("output valid outside the output wait state");

    // The shared unit is never restarted while it is still working.
    assert property (@(posedge clk) disable iff (!rst_n)
        md_start |-> !md_busy)
        else $error("multiply-divide started while busy");

    // A final result hands control back to idle after its transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && last_of_run) |=> in_ready)
        else $error("block not idle after the last result");

    // Clipping never keeps more than two hits.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lvcs_pkg::ST_CLIP_END) |-> nh_reg != 2'd3)
        else $error("hit count overflow");

endmodule

@@ sv/lvcs_muldiv.sv @@
// ----------------------------------------------------------------------------
// lvcs_muldiv: iterative signed multiply-divide
// Computes a * b / d truncated toward zero, magnitude saturated to 2^40,
// by a shift-add multiply followed by a restoring divide, one bit a cycle.
// ----------------------------------------------------------------------------
module lvcs_muldiv
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    start,
    input  logic signed [lvcs_pkg::DIFF_W-1:0]      a,
    input  logic signed [lvcs_pkg::DIFF_W-1:0]      b,
    input  logic signed [lvcs_pkg::DIFF_W-1:0]      d,
    output logic                                    done,
    output logic                                    busy,
    output logic signed [lvcs_pkg::QUO_W-1:0]       q
);

    localparam int W  = lvcs_pkg::DIFF_W;
    localparam int PW = 2 * W;
    localparam int QW = lvcs_pkg::QUO_W - 1;

    lvcs_pkg::md_state_t state_reg, state_next;

    logic [W-1:0]        ua_reg, ua_next, ub_reg, ub_next, ud_reg, ud_next;
    logic                neg_reg, neg_next;
    logic [PW-1:0]       prod_reg, prod_next;
    logic [W-1:0]        rem_reg, rem_next;
    logic [QW-1:0]       quo_reg, quo_next;
    logic                ovf_reg, ovf_next;
    logic [6:0]          cnt_reg, cnt_next;
    logic                done_reg, done_next;
    logic signed [QW:0]  q_reg, q_next;

    logic [W:0]          trial;
    logic                qbit;
    logic [QW-1:0]       mag;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lvcs_pkg::MD_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ua_reg   <= ua_next;
        ub_reg   <= ub_next;
        ud_reg   <= ud_next;
        neg_reg  <= neg_next;
        prod_reg <= prod_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        ovf_reg  <= ovf_next;
        cnt_reg  <= cnt_next;
        q_reg    <= q_next;
    end

    always_comb
    begin
        state_next = state_reg;
        ua_next    = ua_reg;
        ub_next    = ub_reg;
        ud_next    = ud_reg;
        neg_next   = neg_reg;
        prod_next  = prod_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        ovf_next   = ovf_reg;
        cnt_next   = cnt_reg;
        q_next     = q_reg;
        done_next  = 1'b0;
        trial      = {rem_reg, prod_reg[PW-1]};
        qbit       = 1'b0;
        mag        = '0;

        unique case (state_reg)
            lvcs_pkg::MD_IDLE:
            begin
                if (start)
                begin
                    ua_next    = a[W-1] ? W'(-a) : W'(a);
                    ub_next    = b[W-1] ? W'(-b) : W'(b);
                    ud_next    = d[W-1] ? W'(-d) : W'(d);
                    neg_next   = (a[W-1] ^ b[W-1]) ^ d[W-1];
                    prod_next  = '0;
                    cnt_next   = 7'(W - 1);
                    state_next = lvcs_pkg::MD_MUL;
                end
            end
            lvcs_pkg::MD_MUL:
            begin
                prod_next = (prod_reg << 1)
                          + (ub_reg[cnt_reg[5:0]] ? PW'(ua_reg) : PW'(0));
                if (cnt_reg == 7'd0)
                begin
                    cnt_next   = 7'(PW - 1);
                    rem_next   = '0;
                    quo_next   = '0;
                    ovf_next   = 1'b0;
                    state_next = lvcs_pkg::MD_DIV;
                end
                else
                begin
                    cnt_next = cnt_reg - 7'd1;
                end
            end
            lvcs_pkg::MD_DIV:
            begin
                if (trial >= {1'b0, ud_reg})
                begin
                    qbit     = 1'b1;
                    rem_next = W'(trial - {1'b0, ud_reg});
                end
                else
                begin
                    rem_next = trial[W-1:0];
                end
                prod_next = prod_reg << 1;
                quo_next  = {quo_reg[QW-2:0], qbit};
                ovf_next  = ovf_reg | (qbit & (cnt_reg > 7'(QW - 1)));
                if (cnt_reg == 7'd0)
                begin
                    // Saturate anything above 2^40 to 2^40.
                    if (ovf_next || quo_next > {1'b1, {(QW-1){1'b0}}})
                        mag = {1'b1, {(QW-1){1'b0}}};
                    else
                        mag = quo_next;
                    q_next     = neg_reg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
                    done_next  = 1'b1;
                    state_next = lvcs_pkg::MD_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg - 7'd1;
                end
            end
            default:
            begin
                state_next = lvcs_pkg::MD_IDLE;
            end
        endcase
    end

    assign done = done_reg;
    assign busy = (state_reg != lvcs_pkg::MD_IDLE);
    assign q    = q_reg;

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: regression bench for line_viewport_clip_sampler
// Drives line requests through the valid/ready input with bursty timing,
// predicts every clipped line or sampled point in the bench itself, and
// checks each output transfer field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;

    localparam int CLK_HALF  = 4;
    localparam int MAX_PTS   = lvcs_pkg::MAX_POINTS_DEF;
    localparam longint Q_SAT = 64'h0000_0100_0000_0000;

    // One line request as presented on the input channel.
    typedef struct {
        logic signed [lvcs_pkg::COORD_W-1:0] sx;
        logic signed [lvcs_pkg::COORD_W-1:0] sy;
        logic signed [lvcs_pkg::COORD_W-1:0] ex;
        logic signed [lvcs_pkg::COORD_W-1:0] ey;
        logic                                inf;
        logic [lvcs_pkg::CNT_W-1:0]          cnt;
    } line_req_t;

    // One drawing primitive as seen on the output channel.
    typedef struct {
        lvcs_pkg::kind_t              kind;
        logic [lvcs_pkg::COORD_W-1:0] ax;
        logic [lvcs_pkg::COORD_W-1:0] ay;
        logic [lvcs_pkg::COORD_W-1:0] bx;
        logic [lvcs_pkg::COORD_W-1:0] by;
        logic                         last;
    } draw_result_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [1:0] cfg_addr;
    logic [lvcs_pkg::COORD_W-1:0] cfg_wdata;
    logic in_valid;
    logic in_ready;
    logic signed [lvcs_pkg::COORD_W-1:0] start_x, start_y, end_x, end_y;
    logic infinite_line;
    logic [lvcs_pkg::CNT_W-1:0] point_count;
    logic out_valid;
    logic out_ready;
    logic [1:0] result_kind;
    logic signed [lvcs_pkg::COORD_W-1:0] out_ax, out_ay, out_bx, out_by;
    logic last_of_run;

    line_viewport_clip_sampler dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .start_x       (start_x),
        .start_y       (start_y),
        .end_x         (end_x),
        .end_y         (end_y),
        .infinite_line (infinite_line),
        .point_count   (point_count),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .result_kind   (result_kind),
        .out_ax        (out_ax),
        .out_ay        (out_ay),
        .out_bx        (out_bx),
        .out_by        (out_by),
        .last_of_run   (last_of_run)
    );

    // Requests waiting to be offered; the head is the one currently on the bus.
    line_req_t    line_queue[$];
    // Drawing results predicted for accepted requests, oldest first.
    draw_result_t expected_draws[$];
    int           mismatch_count = 0;

    // The bench's own copy of the viewport, kept sign-extended.
    longint view_l, view_r, view_b, view_t;

    // Border hits collected while clipping one infinite line.
    longint hit_x[2];
    longint hit_y[2];
    int     hit_n;

    // Sender burst shaping and receiver stall shaping.
    int burst_left = 0;
    int gap_left   = 0;
    int pat_mode   = 0;
    int pat_left   = 0;
    int long_hold  = 0;
    bit hold_request = 0;
    bit hold_done    = 0;

    always
    begin
        clk = 1'b1;
        #CLK_HALF;
        clk = 1'b0;
        #CLK_HALF;
    end

    // a * b / d, truncated toward zero, magnitude saturated at 2^40.
    function automatic longint scaled_quotient(longint a, longint b, longint d);
        logic [127:0] ma, mb, md, q;
        bit neg;
        longint mag;
        neg = ((a < 0) != (b < 0)) != (d < 0);
        ma = (a < 0) ? 128'(-a) : 128'(a);
        mb = (b < 0) ? 128'(-b) : 128'(b);
        md = (d < 0) ? 128'(-d) : 128'(d);
        q = (ma * mb) / md;
        if (q > 128'(Q_SAT))
        begin
            q = 128'(Q_SAT);
        end
        mag = longint'(q[63:0]);
        return neg ? -mag : mag;
    endfunction

    // Keeps a border hit unless it repeats one already kept (a corner).
    function automatic void note_hit(longint x, longint y);
        for (int k = 0; k < hit_n; k++)
        begin
            if (hit_x[k] == x && hit_y[k] == y)
            begin
                return;
            end
        end
        if (hit_n < 2)
        begin
            hit_x[hit_n] = x;
            hit_y[hit_n] = y;
            hit_n++;
        end
    endfunction

    function automatic void push_draw(lvcs_pkg::kind_t kind, longint ax, longint ay,
                                      longint bx, longint by, logic last);
        draw_result_t d;
        d.kind = kind;
        d.ax = ax[31:0];
        d.ay = ay[31:0];
        d.bx = bx[31:0];
        d.by = by[31:0];
        d.last = last;
        expected_draws.push_back(d);
    endfunction

    // Works out every result that one accepted request should produce.
    function automatic void predict_draws(line_req_t r);
        longint sx, sy, ex, ey, dx, dy, ax, ay, bx, by, c;
        int n;
        sx = r.sx;
        sy = r.sy;
        ex = r.ex;
        ey = r.ey;
        ax = sx;
        ay = sy;
        bx = ex;
        by = ey;
        if (r.inf)
        begin
            dx = ex - sx;
            dy = ey - sy;
            if (dx == 0 && dy == 0)
            begin
                push_draw(lvcs_pkg::KIND_NOTHING, 0, 0, 0, 0, 1'b1);
                return;
            end
            hit_n = 0;
            if (dx != 0)
            begin
                c = sy + scaled_quotient(dy, view_l - sx, dx);
                if (c >= view_b && c <= view_t) note_hit(view_l, c);
                c = sy + scaled_quotient(dy, view_r - sx, dx);
                if (c >= view_b && c <= view_t) note_hit(view_r, c);
            end
            else if (sx >= view_l && sx <= view_r)
            begin
                note_hit(sx, view_b);
                note_hit(sx, view_t);
            end
            if (dy != 0)
            begin
                c = sx + scaled_quotient(dx, view_b - sy, dy);
                if (c >= view_l && c <= view_r) note_hit(c, view_b);
                c = sx + scaled_quotient(dx, view_t - sy, dy);
                if (c >= view_l && c <= view_r) note_hit(c, view_t);
            end
            else if (sy >= view_b && sy <= view_t)
            begin
                note_hit(view_l, sy);
                note_hit(view_r, sy);
            end
            if (hit_n < 2)
            begin
                push_draw(lvcs_pkg::KIND_NOTHING, 0, 0, 0, 0, 1'b1);
                return;
            end
            ax = hit_x[0];
            ay = hit_y[0];
            bx = hit_x[1];
            by = hit_y[1];
        end
        if (r.cnt == 0)
        begin
            push_draw(lvcs_pkg::KIND_LINE, ax, ay, bx, by, 1'b1);
            return;
        end
        n = (r.cnt > MAX_PTS) ? MAX_PTS : int'(r.cnt);
        for (int i = 0; i < n; i++)
        begin
            if (n > 1)
            begin
                push_draw(lvcs_pkg::KIND_POINT, ax + (bx - ax) * i / (n - 1),
                          ay + (by - ay) * i / (n - 1), 0, 0, i == n - 1);
            end
            else
            begin
                push_draw(lvcs_pkg::KIND_POINT, ax, ay, 0, 0, 1'b1);
            end
        end
    endfunction

    function automatic line_req_t mk(longint sx, longint sy, longint ex, longint ey,
                                     int inf, int cnt);
        line_req_t r;
        r.sx = sx[31:0];
        r.sy = sy[31:0];
        r.ex = ex[31:0];
        r.ey = ey[31:0];
        r.inf = inf[0];
        r.cnt = cnt[lvcs_pkg::CNT_W-1:0];
        return r;
    endfunction

    // Coordinates are mostly near the viewport, sometimes anywhere at all.
    function automatic longint rand_coord();
        if ($urandom_range(0, 3) == 0)
        begin
            return longint'($signed($urandom()));
        end
        return longint'($urandom_range(0, 3932160)) - 1966080;
    endfunction

    function automatic line_req_t rand_req();
        line_req_t r;
        int sel, cnt;
        r = mk(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
               int'($urandom_range(0, 1)), 0);
        sel = $urandom_range(0, 19);
        // Axis-aligned and degenerate lines get their share of the traffic.
        if (sel < 2) r.ex = r.sx;
        else if (sel < 4) r.ey = r.sy;
        else if (sel == 4)
        begin
            r.ex = r.sx;
            r.ey = r.sy;
        end
        // Point runs are slow, so most counts stay small.
        sel = $urandom_range(0, 19);
        if (sel < 14) cnt = $urandom_range(0, 4);
        else if (sel < 19) cnt = $urandom_range(5, 16);
        else cnt = $urandom_range(17, 127);
        r.cnt = cnt[lvcs_pkg::CNT_W-1:0];
        return r;
    endfunction

    // Input driver: offers the head of the queue in bursts with random gaps.
    always @(posedge clk)
    begin
        logic nxt_valid;
        if (rst_n)
        begin
            nxt_valid = in_valid;
            if (in_valid && in_ready)
            begin
                predict_draws(line_queue.pop_front());
                nxt_valid = 1'b0;
            end
            if (!(in_valid && !in_ready))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    nxt_valid = 1'b0;
                end
                else if (line_queue.size() > 0)
                begin
                    start_x       <= line_queue[0].sx;
                    start_y       <= line_queue[0].sy;
                    end_x         <= line_queue[0].ex;
                    end_y         <= line_queue[0].ey;
                    infinite_line <= line_queue[0].inf;
                    point_count   <= line_queue[0].cnt;
                    nxt_valid = 1'b1;
                    if (burst_left == 0)
                    begin
                        burst_left = $urandom_range(1, 12);
                        gap_left = $urandom_range(0, 1) ? $urandom_range(1, 15) : 0;
                    end
                    else
                    begin
                        burst_left--;
                    end
                end
                else
                begin
                    nxt_valid = 1'b0;
                end
            end
            in_valid <= nxt_valid;
        end
    end

    // Output receiver: switches between free-flowing, patchy and mostly
    // stalled, and once holds off for a long stretch on request.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_request && !hold_done)
            begin
                long_hold = 600;
                hold_done = 1'b1;
            end
            if (long_hold > 0)
            begin
                long_hold--;
                out_ready <= 1'b0;
            end
            else
            begin
                if (pat_left == 0)
                begin
                    pat_mode = $urandom_range(0, 2);
                    pat_left = $urandom_range(5, 60);
                end
                else
                begin
                    pat_left--;
                end
                case (pat_mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= ($urandom_range(0, 1) == 1);
                    default: out_ready <= ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    // Output monitor: each transfer is checked against the oldest prediction.
    always @(posedge clk)
    begin
        draw_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_draws.size() == 0)
            begin
                $display("%0t: result with nothing expected: kind %0d ax %h ay %h",
                         $time, result_kind, out_ax, out_ay);
                mismatch_count++;
            end
            else
            begin
                want = expected_draws.pop_front();
                if (result_kind !== want.kind)
                begin
                    $display("%0t: result_kind expected %0d actual %0d",
                             $time, want.kind, result_kind);
                    mismatch_count++;
                end
                if (out_ax !== want.ax)
                begin
                    $display("%0t: out_ax expected %h actual %h", $time, want.ax, out_ax);
                    mismatch_count++;
                end
                if (out_ay !== want.ay)
                begin
                    $display("%0t: out_ay expected %h actual %h", $time, want.ay, out_ay);
                    mismatch_count++;
                end
                if (out_bx !== want.bx)
                begin
                    $display("%0t: out_bx expected %h actual %h", $time, want.bx, out_bx);
                    mismatch_count++;
                end
                if (out_by !== want.by)
                begin
                    $display("%0t: out_by expected %h actual %h", $time, want.by, out_by);
                    mismatch_count++;
                end
                if (last_of_run !== want.last)
                begin
                    $display("%0t: last_of_run expected %0b actual %0b",
                             $time, want.last, last_of_run);
                    mismatch_count++;
                end
            end
        end
    end

    // Writes one viewport register and mirrors it in the bench's copy.
    task automatic write_view(lvcs_pkg::cfg_index_t idx, logic [31:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        case (idx)
            lvcs_pkg::REG_LEFT:   view_l = longint'($signed(value));
            lvcs_pkg::REG_RIGHT:  view_r = longint'($signed(value));
            lvcs_pkg::REG_BOTTOM: view_b = longint'($signed(value));
            default:              view_t = longint'($signed(value));
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_viewport(logic [31:0] l, logic [31:0] r, logic [31:0] b,
                                logic [31:0] t);
        write_view(lvcs_pkg::REG_LEFT, l);
        write_view(lvcs_pkg::REG_RIGHT, r);
        write_view(lvcs_pkg::REG_BOTTOM, b);
        write_view(lvcs_pkg::REG_TOP, t);
    endtask

    // Sender pause: waits until every request has gone and every result has
    // come back, leaving the block idle for the next register writes.
    task automatic drain();
        while (line_queue.size() > 0 || in_valid || expected_draws.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);
    endtask

    task automatic queue_random(int count);
        repeat (count) line_queue.push_back(rand_req());
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_addr      = lvcs_pkg::REG_LEFT;
        cfg_wdata     = '0;
        in_valid      = 1'b0;
        start_x       = '0;
        start_y       = '0;
        end_x         = '0;
        end_y         = '0;
        infinite_line = 1'b0;
        point_count   = '0;
        out_ready     = 1'b0;
        view_l = lvcs_pkg::VIEW_LEFT_RST;
        view_r = lvcs_pkg::VIEW_RIGHT_RST;
        view_b = lvcs_pkg::VIEW_BOTTOM_RST;
        view_t = lvcs_pkg::VIEW_TOP_RST;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed requests against the reset viewport of +-10.0.
        line_queue.push_back(mk(65536, 131072, 196608, -262144, 0, 0));
        line_queue.push_back(mk(-2147483648, 2147483647, 2147483647, -2147483648, 0, 0));
        line_queue.push_back(mk(-2147483648, 2147483647, 2147483647, -2147483648, 0, 5));
        line_queue.push_back(mk(12345, -6789, 12345, -6789, 0, 3));
        line_queue.push_back(mk(40000, 40000, 40000, 40000, 1, 0));
        // A diagonal through both corners gives repeated hits to merge.
        line_queue.push_back(mk(0, 0, 65536, 65536, 1, 0));
        line_queue.push_back(mk(196608, 0, 196608, 65536, 1, 0));
        line_queue.push_back(mk(0, -163840, 65536, -163840, 1, 4));
        line_queue.push_back(mk(1310720, 0, 1310720, 65536, 1, 0));
        line_queue.push_back(mk(0, 1966080, 65536, 2031616, 1, 2));
        line_queue.push_back(mk(-2147483648, -2147483648, 2147483647, 2147483647, 1, 2));
        line_queue.push_back(mk(-100000, 70000, 90000, -30000, 0, 1));
        line_queue.push_back(mk(-100000, 70000, 90000, -30000, 0, 64));
        line_queue.push_back(mk(-100000, 70000, 90000, -30000, 0, 127));
        line_queue.push_back(mk(-655360, 5, -655360, 77, 1, 0));
        // Touches only the top right corner, so the viewport counts as missed.
        line_queue.push_back(mk(655360, 655360, 0, 1310720, 1, 0));
        line_queue.push_back(mk(-300000, -1, 250000, 17, 1, 64));
        line_queue.push_back(mk(2147483647, 0, -2147483648, 1, 1, 3));
        drain();

        // Random traffic with one long receiver hold-off while requests wait.
        hold_request = 1'b1;
        queue_random(50);
        drain();

        set_viewport(-($urandom_range(1, 2000000)), $urandom_range(1, 2000000),
                     -($urandom_range(1, 2000000)), $urandom_range(1, 2000000));
        queue_random(35);
        drain();

        // Widest possible viewport.
        set_viewport(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
        line_queue.push_back(mk(-2147483648, -2147483648, 2147483647, 2147483647, 1, 0));
        line_queue.push_back(mk(0, 0, 3, 1, 1, 5));
        line_queue.push_back(mk(-2147483648, 0, -2147483648, 1, 1, 0));
        queue_random(25);
        drain();

        // Inverted viewport.
        set_viewport(327680, -327680, 655360, -655360);
        line_queue.push_back(mk(0, 0, 65536, 0, 1, 0));
        queue_random(12);
        drain();

        // Viewport shrunk to the single point at the origin.
        set_viewport(0, 0, 0, 0);
        line_queue.push_back(mk(-65536, -65536, 65536, 65536, 1, 0));
        line_queue.push_back(mk(0, -65536, 0, 65536, 1, 2));
        queue_random(12);
        drain();

        repeat (50) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("line_viewport_clip_sampler regression: pass");
        end
        else
        begin
            $display("line_viewport_clip_sampler regression: fail");
        end
        $finish;
    end

    // Watchdog well beyond the slowest correct run.
    initial
    begin
        #100000000;
        $display("line_viewport_clip_sampler regression: fail");
        $finish;
    end

endmodule
